// ----- rtl/mts_pkg.sv -----
// Shared constants, codes and types of the min-tracking stack.
`default_nettype none

package mts_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int OCC_W       = 7;
   localparam int STATUS_W    = 2;
   localparam int RSP_FIELD_W = 2 * DATA_WIDTH + 1 + OCC_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_DONE = 1'b1
   } state_type;

   typedef struct packed {
      logic                  we;
      logic [ADDR_W-1:0]     waddr;
      logic [DATA_WIDTH-1:0] wdata;
      logic                  re;
      logic [ADDR_W-1:0]     raddr;
   } mem_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] value_count;
      logic [CNT_W-1:0] min_count;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/min_tracking_stack_top.sv -----
// Top level of the min-tracking stack: sequencer and the two stack memories.
//
//   channel | dir | tdata (low bit up)                              | tuser
//   req_    | in  | push_value[31:0]                                | cmd
//   rsp_    | out | top_value, min_value, is_empty, occupancy       | status
//
// In S_IDLE an accepted request updates the counts and issues reads of the entries
// below the tops; in S_DONE the sequencer takes the registered read data and loads
// the result register. A new request is taken only in S_IDLE, so none is accepted
// while the last is in flight; the stack memories have a registered read.
// Synchronous active-high reset clears the counts; memories are not cleared.
// A waiting result does not block acceptance; the sequencer holds in S_DONE
// until the result register frees up.
`default_nettype none

module min_tracking_stack_top import mts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_WIDTH-1:0] req_tdata,   // push_value
   input  logic                  req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // top_value, min_value, is_empty, occupancy
   output logic [STATUS_W-1:0]   rsp_tuser    // status
);

   mem_req_type           vmem_req;
   mem_req_type           mmem_req;
   logic [DATA_WIDTH-1:0] vmem_rdata;
   logic [DATA_WIDTH-1:0] mmem_rdata;
   stat_type              stat;

   mts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .vmem_req   (vmem_req),
      .mmem_req   (mmem_req),
      .vmem_rdata (vmem_rdata),
      .mmem_rdata (mmem_rdata),
      .stat       (stat)
   );

   mts_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_value_ram (
      .clock (clock),
      .we    (vmem_req.we),
      .waddr (vmem_req.waddr),
      .wdata (vmem_req.wdata),
      .re    (vmem_req.re),
      .raddr (vmem_req.raddr),
      .rdata (vmem_rdata)
   );

   mts_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (DATA_WIDTH)
   ) u_min_ram (
      .clock (clock),
      .we    (mmem_req.we),
      .waddr (mmem_req.waddr),
      .wdata (mmem_req.wdata),
      .re    (mmem_req.re),
      .raddr (mmem_req.raddr),
      .rdata (mmem_rdata)
   );

   // minimum stack never outgrows the value stack and is empty only with it
   a_min_count: assert property (@(posedge clock) disable iff (reset)
      (stat.min_count <= stat.value_count) &&
      ((stat.min_count == '0) == (stat.value_count == '0)))
      else $error("minimum stack count out of step with value stack");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction accepted while one is in flight");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2*DATA_WIDTH]) |->
      (rsp_tdata[2*DATA_WIDTH-1:0] == '0) &&
      (rsp_tdata[2*DATA_WIDTH+1 +: OCC_W] == '0))
      else $error("empty result with nonzero top, minimum or occupancy");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      !(vmem_req.we && vmem_req.re) && !(mmem_req.we && mmem_req.re))
      else $error("push and pop memory accesses in the same cycle");

endmodule

`default_nettype wire

// ----- rtl/mts_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none

module mts_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/mts_ctrl.sv -----
// Stack sequencer: counts, cached top and minimum, memory requests, result register.
`default_nettype none

module mts_ctrl import mts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [DATA_WIDTH-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser,
   output mem_req_type           vmem_req,
   output mem_req_type           mmem_req,
   input  logic [DATA_WIDTH-1:0] vmem_rdata,
   input  logic [DATA_WIDTH-1:0] mmem_rdata,
   output stat_type              stat
);

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       mcount_ff, mcount_in;
   logic [DATA_WIDTH-1:0]  top_ff, top_in;
   logic [DATA_WIDTH-1:0]  min_ff, min_in;
   status_type             status_ff, status_in;
   logic                   pop_ok_ff, pop_ok_in;
   logic                   min_pop_ff, min_pop_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]    rsp_user_ff, rsp_user_in;
   logic [DATA_WIDTH-1:0]  new_top;
   logic [DATA_WIDTH-1:0]  new_min;
   logic                   push_min;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mcount_ff    <= mcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      min_ff      <= min_in;
      status_ff   <= status_in;
      pop_ok_ff   <= pop_ok_in;
      min_pop_ff  <= min_pop_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mcount_in    = mcount_ff;
      top_in       = top_ff;
      min_in       = min_ff;
      status_in    = status_ff;
      pop_ok_in    = pop_ok_ff;
      min_pop_in   = min_pop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = (state_ff == S_IDLE);

      // a push goes onto the minimum stack if the stack is empty or value <= minimum
      push_min = (count_ff == '0) || ($signed(req_tdata) <= $signed(min_ff));

      vmem_req.we    = 1'b0;
      vmem_req.waddr = count_ff[ADDR_W-1:0];
      vmem_req.wdata = req_tdata;
      vmem_req.re    = 1'b0;
      vmem_req.raddr = ADDR_W'(count_ff - CNT_W'(2));
      mmem_req.we    = 1'b0;
      mmem_req.waddr = mcount_ff[ADDR_W-1:0];
      mmem_req.wdata = req_tdata;
      mmem_req.re    = 1'b0;
      mmem_req.raddr = ADDR_W'(mcount_ff - CNT_W'(2));

      new_top = pop_ok_ff  ? vmem_rdata : top_ff;
      new_min = min_pop_ff ? mmem_rdata : min_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in   = S_DONE;
               status_in  = ST_OK;
               pop_ok_in  = 1'b0;
               min_pop_in = 1'b0;
               if (req_tuser == CMD_PUSH) begin
                  if (count_ff == CNT_FULL) begin
                     status_in = ST_FULL;
                  end else begin
                     vmem_req.we = 1'b1;
                     count_in    = count_ff + CNT_W'(1);
                     top_in      = req_tdata;
                     if (push_min) begin
                        mmem_req.we = 1'b1;
                        mcount_in   = mcount_ff + CNT_W'(1);
                        min_in      = req_tdata;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     // fetch the entries that become the new tops
                     pop_ok_in   = 1'b1;
                     vmem_req.re = 1'b1;
                     count_in    = count_ff - CNT_W'(1);
                     if (top_ff == min_ff) begin
                        min_pop_in  = 1'b1;
                        mmem_req.re = 1'b1;
                        mcount_in   = mcount_ff - CNT_W'(1);
                     end
                  end
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in     = S_IDLE;
               top_in       = new_top;
               min_in       = new_min;
               pop_ok_in    = 1'b0;
               min_pop_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = '0;
               if (count_ff != '0) begin
                  rsp_data_in[DATA_WIDTH-1:0]            = new_top;
                  rsp_data_in[2*DATA_WIDTH-1:DATA_WIDTH] = new_min;
               end
               rsp_data_in[2*DATA_WIDTH] = (count_ff == '0);
               rsp_data_in[2*DATA_WIDTH+1 +: OCC_W] = OCC_W'(count_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;
   assign rsp_tuser        = rsp_user_ff;
   assign stat.value_count = count_ff;
   assign stat.min_count   = mcount_ff;

endmodule

`default_nettype wire

// ----- test/min_tracking_stack_top_test.sv -----
// Self-checking testbench for the min-tracking stack: directed and random push/pop streams with stalls.
`default_nettype none

module min_tracking_stack_top_test import mts_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int ITEMS_PER_RUN  = 120;
   localparam int PRESSURE_HOLD  = 250;
   localparam int DRAIN_CYCLES   = 10;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] top_value;
      logic signed [DATA_WIDTH-1:0] min_value;
      logic                         is_empty;
      logic [OCC_W-1:0]             occupancy;
      status_type                   status;
   } stack_result_type;

   // Shadow copy of the stack and its minimum stack; predicts one result per transaction.
   class min_stack_tracker;
      logic signed [DATA_WIDTH-1:0] values [STACK_DEPTH];
      logic signed [DATA_WIDTH-1:0] minimums [STACK_DEPTH];
      int                           depth_used;
      int                           min_used;
      stack_result_type             expected_results [$];
      int                           failures;

      function new();
         depth_used = 0;
         min_used   = 0;
         failures   = 0;
      endfunction

      function void note_request(logic cmd, logic signed [DATA_WIDTH-1:0] value);
         stack_result_type r;
         logic signed [DATA_WIDTH-1:0] popped;
         r.status = ST_OK;
         if (cmd == CMD_PUSH) begin
            if (depth_used >= STACK_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               values[depth_used] = value;
               depth_used++;
               if (min_used == 0 || value <= minimums[min_used-1]) begin
                  minimums[min_used] = value;
                  min_used++;
               end
            end
         end else begin
            if (depth_used == 0) begin
               r.status = ST_EMPTY;
            end else begin
               popped = values[depth_used-1];
               if (min_used > 0 && popped == minimums[min_used-1])
                  min_used--;
               depth_used--;
            end
         end
         r.top_value = (depth_used > 0) ? values[depth_used-1] : '0;
         r.min_value = (depth_used > 0 && min_used > 0) ? minimums[min_used-1] : '0;
         r.is_empty  = (depth_used == 0);
         r.occupancy = OCC_W'(depth_used);
         expected_results.push_back(r);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
         stack_result_type e;
         logic signed [DATA_WIDTH-1:0] got_top;
         logic signed [DATA_WIDTH-1:0] got_min;
         logic                         got_empty;
         logic [OCC_W-1:0]             got_occ;
         got_top   = tdata[DATA_WIDTH-1:0];
         got_min   = tdata[2*DATA_WIDTH-1:DATA_WIDTH];
         got_empty = tdata[2*DATA_WIDTH];
         got_occ   = tdata[2*DATA_WIDTH+1 +: OCC_W];
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, top %0d min %0d occupancy %0d status %0d",
                     $time, got_top, got_min, got_occ, tuser);
            failures++;
            return;
         end
         e = expected_results.pop_front();
         if (got_top !== e.top_value) begin
            $display("%0t: top_value expected %0d actual %0d", $time, e.top_value, got_top);
            failures++;
         end
         if (got_min !== e.min_value) begin
            $display("%0t: min_value expected %0d actual %0d", $time, e.min_value, got_min);
            failures++;
         end
         if (got_empty !== e.is_empty) begin
            $display("%0t: is_empty expected %0d actual %0d", $time, e.is_empty, got_empty);
            failures++;
         end
         if (got_occ !== e.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, e.occupancy, got_occ);
            failures++;
         end
         if (tuser !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, tuser);
            failures++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_WIDTH-1:0] req_tdata  = '0;      // push_value
   logic                  req_tuser  = CMD_PUSH; // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;            // top_value, min_value, is_empty, occupancy
   logic [STATUS_W-1:0]   rsp_tuser;            // status

   min_stack_tracker tracker = new();

   int sender_idle_pct  = 0;
   int receiver_stall_pct = 0;
   int hold_left        = 0;
   int cycle_count      = 0;

   min_tracking_stack_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("min_tracking_stack_top test failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long counted hold-off when requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata, rsp_tuser);
   end

   task automatic send_item(logic cmd, logic [DATA_WIDTH-1:0] value);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < sender_idle_pct)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      tracker.note_request(cmd, value);
   endtask

   // Half small values so equal minimums recur; some full-range and extreme values.
   function automatic logic [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: pick_value = DATA_WIDTH'($urandom_range(0, 20)) - DATA_WIDTH'(10);
         5: begin
            case ($urandom_range(0, 3))
               0: pick_value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
               1: pick_value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
               2: pick_value = '0;
               default: pick_value = '1;
            endcase
         end
         default: pick_value = $urandom;
      endcase
   endfunction

   task automatic random_run(int push_pct, int count);
      repeat (count) begin
         if ($urandom_range(0, 99) < push_pct)
            send_item(CMD_PUSH, pick_value());
         else
            send_item(CMD_POP, $urandom);
      end
   endtask

   initial begin
      int tx_idle [4]  = '{0, 69, 0, 9};
      int rx_stall [4] = '{0, 0, 69, 9};
      int push_bias [3] = '{85, 50, 15};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pops on empty, extremes, duplicate minimums, drain and refill.
      send_item(CMD_POP, $urandom);
      send_item(CMD_PUSH, 32'd5);
      send_item(CMD_PUSH, 32'd5);
      send_item(CMD_PUSH, 32'd7);
      send_item(CMD_PUSH, 32'd3);
      send_item(CMD_PUSH, 32'h8000_0000);
      send_item(CMD_PUSH, 32'h7FFF_FFFF);
      send_item(CMD_PUSH, 32'h8000_0000);
      send_item(CMD_PUSH, 32'hFFFF_FFFF);
      repeat (9) send_item(CMD_POP, $urandom);
      send_item(CMD_POP, $urandom);
      send_item(CMD_PUSH, 32'h7FFF_FFFF);
      send_item(CMD_PUSH, 32'd0);
      send_item(CMD_PUSH, 32'h7FFF_FFFF);
      repeat (3) send_item(CMD_POP, 32'hFFFF_FFFF);

      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = tx_idle[phase];
         receiver_stall_pct = rx_stall[phase];
         if (phase == 0)
            hold_left = PRESSURE_HOLD;
         // push-heavy run fills the stack (overflows), pop-heavy run drains it (underflows)
         for (int run = 0; run < 3; run++)
            random_run(push_bias[run], ITEMS_PER_RUN);
      end
      req_tvalid <= 1'b0;

      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.failures++;

      if (tracker.failures == 0)
         $display("min_tracking_stack_top test passed");
      else
         $display("min_tracking_stack_top test failed");
      $finish;
   end

endmodule

`default_nettype wire
